[rtl/binary_trie_max_xor_engine_unit_defines.svh]
// assertion macros for the binary trie max-xor engine
// used by the top level; expects signals clock and reset in scope
`ifndef BINARY_TRIE_MAX_XOR_ENGINE_UNIT_DEFINES_SVH
`define BINARY_TRIE_MAX_XOR_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication
`define TBM_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tbm assertion failed");

// next-cycle implication
`define TBM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tbm assertion failed");

`endif

[rtl/tbm_pkg.sv]
// shared types and codes for the binary trie max-xor engine
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tbm_pkg;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_QUERY  = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STS_OK         = 2'd0,
      STS_FULL       = 2'd1,
      STS_NO_PARTNER = 2'd2,
      STS_ABSENT     = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_WRD,
      S_WEX,
      S_CHECK,
      S_QSEL,
      S_QEX,
      S_IE1,
      S_IE2,
      S_RE2,
      S_RE3,
      S_QE1,
      S_QE2,
      S_QE3,
      S_QE4,
      S_FIN
   } state_type;

endpackage

`default_nettype wire

[rtl/binary_trie_max_xor_engine_unit.sv]
// insert and remove walk the trie twice, a check pass then a write pass;
// query walks it once. one request in flight at a time; the next is taken in idle
// after the response is loaded; per-level node read-then-write sets the pace.
// reset clears the control state at once; unwritten node and free-list entries are
// masked by fill marks, so no clearing pass is needed.
// top level of the binary trie max-xor engine: sequencer, node and entry stores
// depends on tbm_pkg, tbm_ram and the defines header
`timescale 1ns / 1ps
`default_nettype none
`include "binary_trie_max_xor_engine_unit_defines.svh"

module binary_trie_max_xor_engine_unit #(
   parameter int KEY_BITS    = 64,
   parameter int NODE_SLOTS  = 65536,
   parameter int LEAF_SLOTS  = 4096,
   parameter int ENTRY_SLOTS = 4096,
   parameter int ID_BITS     = 20
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [87:0] req_tdata,   // key[63:0], item_id[83:64], zero pad
   input  wire logic [1:0]  req_tuser,   // command[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // result_id[19:0], zero pad
   output logic [1:0]       rsp_tuser    // status[1:0]
);

   import tbm_pkg::*;

   localparam int NAW = $clog2(NODE_SLOTS);
   localparam int NFW = $clog2(NODE_SLOTS + 1);
   localparam int LAW = $clog2(LEAF_SLOTS);
   localparam int LFW = $clog2(LEAF_SLOTS + 1);
   localparam int LKW = (NAW > LFW) ? NAW : LFW;
   localparam int EAW = $clog2(ENTRY_SLOTS);
   localparam int EFW = $clog2(ENTRY_SLOTS + 1);
   localparam int PW  = EFW;
   localparam int NWW = 2 * LKW + PW;
   localparam int LVW = $clog2(KEY_BITS + 1);
   localparam int CW  = $clog2(NODE_SLOTS + KEY_BITS + 1);
   localparam int IDW = (ID_BITS < 20) ? ID_BITS : 20;

   // control and payload registers
   state_type        state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [KEY_BITS-1:0] key_ff, key_in, ksh_ff, ksh_in;
   logic [IDW-1:0]   id_ff, id_in;
   logic [LVW-1:0]   lvl_ff, lvl_in;
   logic [NAW-1:0]   node_ff, node_in;
   logic             pass2_ff, pass2_in;
   logic             newleaf_ff, newleaf_in;
   logic             try_ff, try_in;
   logic [NWW-1:0]   nd_ff, nd_in;
   logic [LAW-1:0]   leaf_ff, leaf_in;
   logic             wasempty_ff, wasempty_in;
   logic [NFW-1:0]   nfn_ff, nfn_in;
   logic [LFW-1:0]   nfl_ff, nfl_in;
   logic [EFW-1:0]   feh_ff, feh_in;
   logic [EFW-1:0]   ehw_ff, ehw_in;
   logic [NFW-1:0]   nhw_ff, nhw_in;
   logic [IDW-1:0]   res_id_ff, res_id_in;
   status_type       res_st_ff, res_st_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [IDW-1:0]   rsp_id_ff, rsp_id_in;
   status_type       rsp_st_ff, rsp_st_in;

   // memory ports
   logic [NAW-1:0]   n_rd_addr, n_wr_addr;
   logic             n_wr_en;
   logic [NWW-1:0]   n_wr_data, n_q, nd_q;
   logic             n_vld_ff;
   logic             h_wr_en, t_wr_en, v_wr_en, l_wr_en;
   logic [EAW-1:0]   h_wr_data, head_q, tail_q;
   logic [EAW-1:0]   v_rd_addr, l_rd_addr, l_wr_addr;
   logic [IDW-1:0]   value_q;
   logic [EFW-1:0]   l_wr_data, l_q, link_q;
   logic             lk_fresh_ff;
   logic [EAW-1:0]   lk_addr_ff;

   // node word fields
   logic [LKW-1:0]   q_zero, q_one, r_zero, r_one, child, qpref, qsame, newc, lnum;
   logic [PW-1:0]    q_pop, r_pop;
   logic             kbit, lvl_full;
   logic [CW-1:0]    need_sum;
   logic [EAW-1:0]   e_idx;

   assign nd_q   = n_vld_ff ? n_q : '0;
   assign q_pop  = nd_q[PW-1:0];
   assign q_one  = nd_q[PW+LKW-1:PW];
   assign q_zero = nd_q[NWW-1:PW+LKW];
   assign r_pop  = nd_ff[PW-1:0];
   assign r_one  = nd_ff[PW+LKW-1:PW];
   assign r_zero = nd_ff[NWW-1:PW+LKW];
   assign kbit     = ksh_ff[KEY_BITS-1];
   assign lvl_full = (lvl_ff == LVW'(KEY_BITS));
   assign child    = kbit ? q_one : q_zero;
   assign qpref    = kbit ? r_zero : r_one;
   assign qsame    = kbit ? r_one : r_zero;
   assign newc     = (cmd_ff == CMD_INSERT && child == '0) ? LKW'(nfn_ff) : child;
   assign lnum     = (q_one == '0) ? (LKW'(nfl_ff) + LKW'(1)) : q_one;
   assign need_sum = CW'(nfn_ff) + CW'(KEY_BITS) - CW'(lvl_ff);
   assign e_idx    = feh_ff[EAW-1:0];
   assign link_q   = lk_fresh_ff ? (EFW'(lk_addr_ff) + EFW'(1)) : l_q;

   tbm_ram #(.WIDTH(NWW), .DEPTH(NODE_SLOTS)) u_node (
      .clock(clock), .wr_en(n_wr_en), .wr_addr(n_wr_addr), .wr_data(n_wr_data),
      .rd_addr(n_rd_addr), .rd_data(n_q)
   );
   tbm_ram #(.WIDTH(EAW), .DEPTH(LEAF_SLOTS)) u_head (
      .clock(clock), .wr_en(h_wr_en), .wr_addr(leaf_ff), .wr_data(h_wr_data),
      .rd_addr(leaf_ff), .rd_data(head_q)
   );
   tbm_ram #(.WIDTH(EAW), .DEPTH(LEAF_SLOTS)) u_tail (
      .clock(clock), .wr_en(t_wr_en), .wr_addr(leaf_ff), .wr_data(e_idx),
      .rd_addr(leaf_ff), .rd_data(tail_q)
   );
   tbm_ram #(.WIDTH(IDW), .DEPTH(ENTRY_SLOTS)) u_value (
      .clock(clock), .wr_en(v_wr_en), .wr_addr(e_idx), .wr_data(id_ff),
      .rd_addr(v_rd_addr), .rd_data(value_q)
   );
   tbm_ram #(.WIDTH(EFW), .DEPTH(ENTRY_SLOTS)) u_link (
      .clock(clock), .wr_en(l_wr_en), .wr_addr(l_wr_addr), .wr_data(l_wr_data),
      .rd_addr(l_rd_addr), .rd_data(l_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         lvl_ff       <= '0;
         nfn_ff       <= NFW'(2);
         nfl_ff       <= '0;
         feh_ff       <= '0;
         ehw_ff       <= '0;
         nhw_ff       <= NFW'(1);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         lvl_ff       <= lvl_in;
         nfn_ff       <= nfn_in;
         nfl_ff       <= nfl_in;
         feh_ff       <= feh_in;
         ehw_ff       <= ehw_in;
         nhw_ff       <= nhw_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      ksh_ff      <= ksh_in;
      id_ff       <= id_in;
      node_ff     <= node_in;
      pass2_ff    <= pass2_in;
      newleaf_ff  <= newleaf_in;
      try_ff      <= try_in;
      nd_ff       <= nd_in;
      leaf_ff     <= leaf_in;
      wasempty_ff <= wasempty_in;
      res_id_ff   <= res_id_in;
      res_st_ff   <= res_st_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_st_ff   <= rsp_st_in;
      n_vld_ff    <= (NFW'(n_rd_addr) < nhw_ff);
      lk_fresh_ff <= (EFW'(l_rd_addr) >= ehw_ff);
      lk_addr_ff  <= l_rd_addr;
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      ksh_in       = ksh_ff;
      id_in        = id_ff;
      lvl_in       = lvl_ff;
      node_in      = node_ff;
      pass2_in     = pass2_ff;
      newleaf_in   = newleaf_ff;
      try_in       = try_ff;
      nd_in        = nd_ff;
      leaf_in      = leaf_ff;
      wasempty_in  = wasempty_ff;
      nfn_in       = nfn_ff;
      nfl_in       = nfl_ff;
      feh_in       = feh_ff;
      ehw_in       = ehw_ff;
      nhw_in       = nhw_ff;
      res_id_in    = res_id_ff;
      res_st_in    = res_st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_id_in    = rsp_id_ff;
      rsp_st_in    = rsp_st_ff;
      req_tready   = 1'b0;
      n_rd_addr    = node_ff;
      n_wr_en      = 1'b0;
      n_wr_addr    = node_ff;
      n_wr_data    = nd_q;
      h_wr_en      = 1'b0;
      h_wr_data    = e_idx;
      t_wr_en      = 1'b0;
      v_wr_en      = 1'b0;
      v_rd_addr    = (state_ff == S_QE3) ? link_q[EAW-1:0] : head_q;
      l_rd_addr    = (state_ff == S_IE1) ? e_idx : head_q;
      l_wr_en      = 1'b0;
      l_wr_addr    = tail_q;
      l_wr_data    = EFW'(e_idx);

      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd_in     = cmd_type'(req_tuser);
               key_in     = req_tdata[KEY_BITS-1:0];
               ksh_in     = req_tdata[KEY_BITS-1:0];
               id_in      = req_tdata[64 +: IDW];
               node_in    = NAW'(1);
               lvl_in     = '0;
               pass2_in   = 1'b0;
               newleaf_in = 1'b0;
               res_id_in  = '0;
               res_st_in  = STS_OK;
               unique case (cmd_type'(req_tuser))
                  CMD_INSERT, CMD_REMOVE, CMD_QUERY: state_in = S_WRD;
                  default:                           state_in = S_FIN;
               endcase
            end
         end
         S_WRD: begin
            state_in = S_WEX;
         end
         S_WEX: begin
            if (cmd_ff == CMD_QUERY) begin
               if (q_pop == '0) begin
                  res_st_in = STS_NO_PARTNER;
                  state_in  = S_FIN;
               end else begin
                  nd_in    = nd_q;
                  state_in = S_QSEL;
               end
            end else if (!pass2_ff) begin
               if (!lvl_full) begin
                  if (child == '0) begin
                     if (cmd_ff == CMD_INSERT) begin
                        newleaf_in = 1'b1;
                        state_in   = S_CHECK;
                     end else begin
                        res_st_in = STS_ABSENT;
                        state_in  = S_FIN;
                     end
                  end else begin
                     node_in  = child[NAW-1:0];
                     lvl_in   = lvl_ff + LVW'(1);
                     ksh_in   = ksh_ff << 1;
                     state_in = S_WRD;
                  end
               end else if (cmd_ff == CMD_INSERT) begin
                  newleaf_in = (q_one == '0);
                  state_in   = S_CHECK;
               end else if (q_pop == '0 || q_one == '0) begin
                  res_st_in = STS_ABSENT;
                  state_in  = S_FIN;
               end else begin
                  leaf_in  = LAW'(q_one - LKW'(1));
                  pass2_in = 1'b1;
                  node_in  = NAW'(1);
                  lvl_in   = '0;
                  ksh_in   = key_ff;
                  state_in = S_WRD;
               end
            end else begin
               n_wr_en = 1'b1;
               if (NFW'(node_ff) >= nhw_ff) begin
                  nhw_in = NFW'(node_ff) + NFW'(1);
               end
               if (!lvl_full) begin
                  n_wr_data[PW-1:0] = (cmd_ff == CMD_INSERT) ? q_pop + PW'(1)
                                                             : q_pop - PW'(1);
                  if (kbit) begin
                     n_wr_data[PW+LKW-1:PW] = newc;
                  end else begin
                     n_wr_data[NWW-1:PW+LKW] = newc;
                  end
                  if (cmd_ff == CMD_INSERT && child == '0) begin
                     nfn_in = nfn_ff + NFW'(1);
                  end
                  node_in  = newc[NAW-1:0];
                  lvl_in   = lvl_ff + LVW'(1);
                  ksh_in   = ksh_ff << 1;
                  state_in = S_WRD;
               end else if (cmd_ff == CMD_INSERT) begin
                  n_wr_data[PW-1:0]      = q_pop + PW'(1);
                  n_wr_data[PW+LKW-1:PW] = lnum;
                  if (q_one == '0) begin
                     nfl_in = nfl_ff + LFW'(1);
                  end
                  wasempty_in = (q_pop == '0);
                  leaf_in     = LAW'(lnum - LKW'(1));
                  state_in    = S_IE1;
               end else begin
                  n_wr_data[PW-1:0] = q_pop - PW'(1);
                  state_in          = S_RE2;
               end
            end
         end
         S_CHECK: begin
            if (need_sum > CW'(NODE_SLOTS) ||
                (newleaf_ff && nfl_ff >= LFW'(LEAF_SLOTS)) ||
                feh_ff >= EFW'(ENTRY_SLOTS)) begin
               res_st_in = STS_FULL;
               state_in  = S_FIN;
            end else begin
               pass2_in = 1'b1;
               node_in  = NAW'(1);
               lvl_in   = '0;
               ksh_in   = key_ff;
               state_in = S_WRD;
            end
         end
         S_QSEL: begin
            if (lvl_full) begin
               if (r_one == '0 || r_pop == '0) begin
                  res_st_in = STS_NO_PARTNER;
                  state_in  = S_FIN;
               end else begin
                  leaf_in  = LAW'(r_one - LKW'(1));
                  state_in = S_QE1;
               end
            end else if (qpref != '0) begin
               n_rd_addr = qpref[NAW-1:0];
               try_in    = 1'b0;
               state_in  = S_QEX;
            end else if (qsame != '0) begin
               n_rd_addr = qsame[NAW-1:0];
               try_in    = 1'b1;
               state_in  = S_QEX;
            end else begin
               res_st_in = STS_NO_PARTNER;
               state_in  = S_FIN;
            end
         end
         S_QEX: begin
            if (q_pop != '0) begin
               nd_in    = nd_q;
               lvl_in   = lvl_ff + LVW'(1);
               ksh_in   = ksh_ff << 1;
               state_in = S_QSEL;
            end else if (!try_ff && qsame != '0) begin
               n_rd_addr = qsame[NAW-1:0];
               try_in    = 1'b1;
            end else begin
               res_st_in = STS_NO_PARTNER;
               state_in  = S_FIN;
            end
         end
         S_IE1: begin
            v_wr_en  = 1'b1;
            state_in = S_IE2;
         end
         S_IE2: begin
            feh_in = link_q;
            if (EFW'(e_idx) == ehw_ff) begin
               ehw_in = ehw_ff + EFW'(1);
            end
            if (wasempty_ff) begin
               h_wr_en = 1'b1;
            end else begin
               l_wr_en = 1'b1;
            end
            t_wr_en  = 1'b1;
            state_in = S_FIN;
         end
         S_RE2: begin
            state_in = S_RE3;
         end
         S_RE3: begin
            h_wr_en   = 1'b1;
            h_wr_data = link_q[EAW-1:0];
            l_wr_en   = 1'b1;
            l_wr_addr = head_q;
            l_wr_data = feh_ff;
            feh_in    = EFW'(head_q);
            state_in  = S_FIN;
         end
         S_QE1: begin
            state_in = S_QE2;
         end
         S_QE2: begin
            state_in = S_QE3;
         end
         S_QE3: begin
            if (value_q != id_ff) begin
               res_id_in = value_q;
               state_in  = S_FIN;
            end else if (r_pop < PW'(2)) begin
               res_st_in = STS_NO_PARTNER;
               state_in  = S_FIN;
            end else begin
               state_in = S_QE4;
            end
         end
         S_QE4: begin
            res_id_in = value_q;
            state_in  = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = res_id_ff;
               rsp_st_in    = res_st_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = 24'(rsp_id_ff);
   assign rsp_tuser  = rsp_st_ff;

   `TBM_ASSERT_NOW(a_free_head_in_fill, 1'b1, feh_ff <= ehw_ff)
   `TBM_ASSERT_NOW(a_level_bound, 1'b1, lvl_ff <= LVW'(KEY_BITS))
   `TBM_ASSERT_NEXT(a_fin_loads_rsp, state_ff == S_FIN && (!rsp_valid_ff || rsp_tready), rsp_tvalid)

endmodule

`default_nettype wire

[rtl/tbm_ram.sv]
// simple dual-port synchronous ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module tbm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
